// ===== design/ncc_pkg.sv =====
// ----------------------------------------------------------------------------
// ncc_pkg: shared types and constants for the nearest-center counter
// Sizes of the client buffer and the count, controller states, and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package ncc_pkg;

  localparam int unsigned PENDING_DEPTH = 1024;
  localparam int unsigned PEND_AW       = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int unsigned FILL_W        = $clog2(PENDING_DEPTH + 1);
  localparam int unsigned POS_W         = 32;
  localparam int unsigned COUNT_W       = 20;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT_L,
    ST_OPEN,
    ST_FLUSH
  } ncc_state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // item taken this cycle
    logic walk;       // step the buffer walk
    logic emit_left;  // close the left center, open the right one
    logic open;       // first center of the set
    logic flush;      // end of set: emit last count if any, clear state
  } ncc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic              have;       // a center is open
    logic              fin;        // held item is the final one
    logic              walk_done;  // all buffered clients classified
    logic              out_free;   // output register can load
    logic [FILL_W-1:0] fill;       // buffered clients
  } ncc_stat_t;

endpackage

// ===== design/nearest_center_count_1d.sv =====
// ----------------------------------------------------------------------------
// nearest_center_count_1d: per-center client counts along a sorted line
// Clients go to the nearest center (ties to the left); one count per center.
// ----------------------------------------------------------------------------
//
// channel  dir  handshake               payload
// -------  ---  ----------------------  -----------------------------------
// in       in   in_valid_i / in_stall_o  position, is_center, final_item
// out      out  out_valid_o/out_stall_i  center_count, last_of_set, overflowed
//
// A client item's position is written into the 1024-entry client buffer in the
// accept cycle (a client that finds the buffer full is dropped and flagged as
// overflow) and the next item can follow right away. A center item after an
// earlier center walks the buffer: the walk reads one entry per cycle through
// its single read port, a 2-stage distance/compare pipeline drains, the walk
// is seen done, then the left count is loaded. A first center passes through
// the open step; a final item adds a flush step.
// Reset is asynchronous, active low; no clearing pass (buffer entries past the
// fill count are never read). A stalled output only holds the block when a
// new count must be loaded while the previous one is still waiting.
// ----------------------------------------------------------------------------
module nearest_center_count_1d (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ncc_pkg::POS_W-1:0]     in_position_i,
  input  logic                          in_is_center_i,
  input  logic                          in_final_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ncc_pkg::COUNT_W-1:0]   out_center_count_o,
  output logic                          out_last_of_set_o,
  output logic                          out_overflowed_o
);

  ncc_pkg::ncc_cmd_t  cmd;
  ncc_pkg::ncc_stat_t stat;

  // sequencer: owns the input handshake
  ncc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_is_center_i  (in_is_center_i),
    .in_final_item_i (in_final_item_i),
    .in_stall_o      (in_stall_o),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  // buffer, walk, tally and output register
  ncc_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .in_position_i      (in_position_i),
    .in_is_center_i     (in_is_center_i),
    .in_final_item_i    (in_final_item_i),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .out_center_count_o (out_center_count_o),
    .out_last_of_set_o  (out_last_of_set_o),
    .out_overflowed_o   (out_overflowed_o)
  );

`ifndef ASSERT_OFF
  // buffer fill never passes its depth
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.fill <= ncc_pkg::FILL_W'(ncc_pkg::PENDING_DEPTH))
    else $error("client buffer fill beyond depth");

  // a count is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_left || (cmd.flush && stat.have)) |-> (!out_valid_o || !out_stall_i))
    else $error("output register overwritten");

  // an accepted center always leaves the block busy, stalling the input
  a_center_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_is_center_i) |=> in_stall_o)
    else $error("center item did not occupy the block");

  // a non-final client never stalls the input in the cycle after it is taken
  a_client_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !in_is_center_i && !in_final_item_i) |=> !in_stall_o)
    else $error("client item stalled the input");
`endif

endmodule

// ===== design/ncc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ncc_ctrl: sequencer for the nearest-center counter
// Steps one item at a time through walk, emit, open and flush phases.
// ----------------------------------------------------------------------------
module ncc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_is_center_i,
  input  logic              in_final_item_i,
  output logic              in_stall_o,
  input  ncc_pkg::ncc_stat_t stat_i,
  output ncc_pkg::ncc_cmd_t  cmd_o
);

  ncc_pkg::ncc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ncc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ncc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_is_center_i) begin
            state_d = stat_i.have ? ncc_pkg::ST_WALK : ncc_pkg::ST_OPEN;
          end else if (in_final_item_i) begin
            state_d = ncc_pkg::ST_FLUSH;
          end
        end
      end
      ncc_pkg::ST_WALK: begin
        if (stat_i.walk_done) begin
          state_d = ncc_pkg::ST_EMIT_L;
        end
      end
      ncc_pkg::ST_EMIT_L: begin
        if (stat_i.out_free) begin
          state_d = stat_i.fin ? ncc_pkg::ST_FLUSH : ncc_pkg::ST_IDLE;
        end
      end
      ncc_pkg::ST_OPEN: begin
        state_d = stat_i.fin ? ncc_pkg::ST_FLUSH : ncc_pkg::ST_IDLE;
      end
      ncc_pkg::ST_FLUSH: begin
        if (!stat_i.have || stat_i.out_free) begin
          state_d = ncc_pkg::ST_IDLE;
        end
      end
      default: state_d = ncc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ncc_pkg::ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ncc_pkg::ST_WALK:   cmd_o.walk      = 1'b1;
      ncc_pkg::ST_EMIT_L: cmd_o.emit_left = stat_i.out_free;
      ncc_pkg::ST_OPEN:   cmd_o.open      = 1'b1;
      ncc_pkg::ST_FLUSH:  cmd_o.flush     = !stat_i.have || stat_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/ncc_dp.sv =====
// ----------------------------------------------------------------------------
// ncc_dp: datapath for the nearest-center counter
// Client buffer, buffer walk pipeline, tally with saturation, output register.
// ----------------------------------------------------------------------------
module ncc_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ncc_pkg::ncc_cmd_t             cmd_i,
  output ncc_pkg::ncc_stat_t            stat_o,
  input  logic [ncc_pkg::POS_W-1:0]     in_position_i,
  input  logic                          in_is_center_i,
  input  logic                          in_final_item_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [ncc_pkg::COUNT_W-1:0]   out_center_count_o,
  output logic                          out_last_of_set_o,
  output logic                          out_overflowed_o
);

  localparam int unsigned AW = ncc_pkg::PEND_AW;
  localparam int unsigned FW = ncc_pkg::FILL_W;
  localparam int unsigned PW = ncc_pkg::POS_W;
  localparam int unsigned CW = ncc_pkg::COUNT_W;

  logic [PW-1:0] mem [ncc_pkg::PENDING_DEPTH];

  // held item
  logic [PW-1:0] pos_q;
  logic          fin_q;

  // set state
  logic [PW-1:0] left_pos_q;
  logic [CW-1:0] tally_q;
  logic          have_q, sat_q;
  logic [FW-1:0] fill_q;

  // walk pipeline: address -> read data -> distances -> counts
  logic [FW-1:0] idx_q;
  logic          v1_q, v2_q;
  logic [PW-1:0] rd_q, dl_q, dr_q;
  logic [FW-1:0] to_left_q, to_right_q;

  // output register
  logic          out_valid_q, out_last_q, out_ov_q;
  logic [CW-1:0] out_count_q;

  logic          full, push, issue, out_free;
  logic [CW:0]   sum;
  logic          sum_sat;
  logic [CW-1:0] sum_clip;

  assign full     = (fill_q == FW'(ncc_pkg::PENDING_DEPTH));
  assign push     = cmd_i.accept && !in_is_center_i && !full;
  assign issue    = cmd_i.walk && (idx_q != fill_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // one adder serves both closing the left center and the final flush
  assign sum      = {1'b0, tally_q}
                  + (cmd_i.emit_left ? (CW+1)'(to_left_q) : (CW+1)'(fill_q));
  assign sum_sat  = (sum > {1'b0, ncc_pkg::COUNT_MAX});
  assign sum_clip = sum_sat ? ncc_pkg::COUNT_MAX : sum[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[fill_q[AW-1:0]] <= in_position_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_q <= in_position_i;
    end
    if (v1_q) begin
      dl_q <= rd_q - left_pos_q;
      dr_q <= pos_q - rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q      <= 1'b0;
      left_pos_q <= '0;
      tally_q    <= '0;
      have_q     <= 1'b0;
      sat_q      <= 1'b0;
      fill_q     <= '0;
    end else begin
      if (cmd_i.accept) begin
        fin_q <= in_final_item_i;
        if (!in_is_center_i) begin
          if (full) begin
            sat_q <= 1'b1;
          end else begin
            fill_q <= fill_q + FW'(1);
          end
        end
      end else if (cmd_i.emit_left) begin
        tally_q    <= CW'(to_right_q);
        sat_q      <= 1'b0;
        have_q     <= 1'b1;
        left_pos_q <= pos_q;
        fill_q     <= '0;
      end else if (cmd_i.open) begin
        tally_q    <= CW'(fill_q);
        have_q     <= 1'b1;
        left_pos_q <= pos_q;
        fill_q     <= '0;
      end else if (cmd_i.flush) begin
        fin_q      <= 1'b0;
        left_pos_q <= '0;
        tally_q    <= '0;
        have_q     <= 1'b0;
        sat_q      <= 1'b0;
        fill_q     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      to_left_q  <= '0;
      to_right_q <= '0;
    end else if (cmd_i.accept) begin
      idx_q      <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      to_left_q  <= '0;
      to_right_q <= '0;
    end else if (cmd_i.walk) begin
      if (issue) begin
        idx_q <= idx_q + FW'(1);
      end
      v1_q <= issue;
      v2_q <= v1_q;
      if (v2_q) begin
        // tie goes left
        if (dr_q >= dl_q) begin
          to_left_q <= to_left_q + FW'(1);
        end else begin
          to_right_q <= to_right_q + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_left || (cmd_i.flush && have_q)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_left || (cmd_i.flush && have_q)) begin
      out_count_q <= sum_clip;
      out_last_q  <= cmd_i.flush;
      out_ov_q    <= sat_q || sum_sat;
    end
  end

  assign stat_o.have      = have_q;
  assign stat_o.fin       = fin_q;
  assign stat_o.walk_done = (idx_q == fill_q) && !v1_q && !v2_q;
  assign stat_o.out_free  = out_free;
  assign stat_o.fill      = fill_q;

  assign out_valid_o        = out_valid_q;
  assign out_center_count_o = out_count_q;
  assign out_last_of_set_o  = out_last_q;
  assign out_overflowed_o   = out_ov_q;

endmodule
